[rtl/cartridge_bank_controller_unit_macros.svh]
// Assertion macros for the cartridge bank controller.
// Included by files that check their own logic; define NO_ASSERTIONS to drop them.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, reset masks the check
`define CBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, reset masks the check
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/cbc_pkg.sv]
// Shared constants, operation codes and types of the cartridge bank controller.
// No dependencies; every other file but the macro header imports it.
`timescale 1ns / 1ps
package cbc_pkg;

  // Bus and field widths
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ROM_BANK_W  = 9;
  localparam int RAM_BANK_W  = 4;
  localparam int ROM_SIZE_W  = 4;
  localparam int RAM_SIZE_W  = 3;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  // Bank geometry
  localparam int RAM_BANK_BYTES    = 8192;
  localparam int ROM_BANK_BYTES    = 16384;
  localparam int MAX_RAM_BANKS_DEF = 16;
  localparam int RAM_OFF_W         = $clog2(RAM_BANK_BYTES);
  localparam int ROM_OFF_W         = $clog2(ROM_BANK_BYTES);
  localparam int ROM_ADDR_W        = ROM_BANK_W + ROM_OFF_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROM_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAM_SIZE = 1'b1;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Misc values
  localparam logic [3:0]        RAM_EN_KEY  = 4'hA;
  localparam logic [DATA_W-1:0] OPEN_BUS    = 8'hFF;
  localparam int                MAX_ROM_EXP = 8;

  // Classified operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_RAM_EN   = 4'd1;
  localparam logic [OP_W-1:0] OP_ROM_LO   = 4'd2;
  localparam logic [OP_W-1:0] OP_ROM_HI   = 4'd3;
  localparam logic [OP_W-1:0] OP_RAM_BANK = 4'd4;
  localparam logic [OP_W-1:0] OP_RAM_WR   = 4'd5;
  localparam logic [OP_W-1:0] OP_RD_ROM0  = 4'd6;
  localparam logic [OP_W-1:0] OP_RD_ROMX  = 4'd7;
  localparam logic [OP_W-1:0] OP_RD_RAM   = 4'd8;
  localparam logic [OP_W-1:0] OP_RD_OPEN  = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } cbc_entry_t;

  // One queue slot with its valid flag
  typedef struct packed {
    logic       valid;
    cbc_entry_t entry;
  } cbc_slot_t;

endpackage

[rtl/cbc_bus_if.sv]
// Request and response channel interfaces of the cartridge bank controller.
// Depends on cbc_pkg for field widths.
`timescale 1ns / 1ps
interface cbc_req_if
  import cbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, cmd, address, write_data, input ready);
  modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

interface cbc_rsp_if
  import cbc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  rom_fetch;
  logic [ROM_ADDR_W-1:0] rom_address;
  logic [DATA_W-1:0]     read_data;

  modport source (output valid, rom_fetch, rom_address, read_data, input ready);
  modport sink   (input valid, rom_fetch, rom_address, read_data, output ready);
endinterface

[rtl/cbc_queue.sv]
// Short FIFO of classified items between the front and the back.
// Depends on cbc_pkg for the slot type and depth.
`timescale 1ns / 1ps
module cbc_queue
  import cbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cbc_slot_t push,
  output logic      full,
  output cbc_slot_t head,
  input  logic      pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cbc_entry_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

[rtl/cbc_front.sv]
// Front end: accepts bus accesses and classifies them by address range.
// Depends on cbc_pkg and the request channel interface.
`timescale 1ns / 1ps
module cbc_front
  import cbc_pkg::*;
(
  cbc_req_if.sink   req,
  input  logic      full,
  input  logic      clear_busy,
  output cbc_slot_t push
);

  logic [OP_W-1:0] op;

  // Classify the access
  always_comb begin
    op = OP_NOP;
    if (req.cmd == CMD_WRITE) begin
      if (req.address inside {[16'h0000:16'h1FFF]}) begin
        op = OP_RAM_EN;
      end else if (req.address inside {[16'h2000:16'h2FFF]}) begin
        op = OP_ROM_LO;
      end else if (req.address inside {[16'h3000:16'h3FFF]}) begin
        op = OP_ROM_HI;
      end else if (req.address inside {[16'h4000:16'h5FFF]}) begin
        op = OP_RAM_BANK;
      end else if (req.address inside {[16'hA000:16'hBFFF]}) begin
        op = OP_RAM_WR;
      end else begin
        op = OP_NOP;
      end
    end else begin
      if (req.address inside {[16'h0000:16'h3FFF]}) begin
        op = OP_RD_ROM0;
      end else if (req.address inside {[16'h4000:16'h7FFF]}) begin
        op = OP_RD_ROMX;
      end else if (req.address inside {[16'hA000:16'hBFFF]}) begin
        op = OP_RD_RAM;
      end else begin
        op = OP_RD_OPEN;
      end
    end
  end

  // Hold off while RAM clears or the queue is full; drop ignored writes
  assign req.ready              = !clear_busy && !full;
  assign push.valid             = req.valid && req.ready && (op != OP_NOP);
  assign push.entry.op          = op;
  assign push.entry.address     = req.address;
  assign push.entry.write_data  = req.write_data;

endmodule

[rtl/cbc_back.sv]
// Back end: bank registers, cartridge RAM, clearing pass and result register.
// Depends on cbc_pkg and the response channel interface.
`timescale 1ns / 1ps
module cbc_back
  import cbc_pkg::*;
#(
  parameter int MAX_RAM_BANKS = MAX_RAM_BANKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  cbc_slot_t              head,
  output logic                   pop,
  output logic                   clear_busy,
  cbc_rsp_if.source              rsp
);

  localparam int RAM_DEPTH = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAW       = $clog2(RAM_DEPTH);
  localparam int CNT_W     = 5;
  localparam int RB_TBL_W  = 8 * 16 * RAM_BANK_W;

  // Usable RAM banks for a size code, capped by the store
  function automatic logic [CNT_W-1:0] ram_banks(logic [RAM_SIZE_W-1:0] code);
    logic [CNT_W-1:0] n;
    case (code)
      3'd1:    n = 5'd1;
      3'd2:    n = 5'd4;
      3'd3:    n = 5'd8;
      3'd4:    n = 5'd16;
      default: n = 5'd0;
    endcase
    if (n > CNT_W'(MAX_RAM_BANKS)) begin
      n = CNT_W'(MAX_RAM_BANKS);
    end
    return n;
  endfunction

  // Reduced RAM bank for every size code and written value
  function automatic logic [RB_TBL_W-1:0] build_rb_tbl();
    logic [RB_TBL_W-1:0] tbl;
    int c;
    int v;
    int k;
    int n;
    int r;
    tbl = '0;
    for (c = 0; c < 8; c++) begin
      for (v = 0; v < 16; v++) begin
        n = int'(ram_banks(RAM_SIZE_W'(c)));
        r = v;
        if (n == 0) begin
          r = 0;
        end else begin
          for (k = 0; k < 16; k++) begin
            if (r >= n) begin
              r = r - n;
            end
          end
        end
        tbl[(c * 16 + v) * RAM_BANK_W +: RAM_BANK_W] = RAM_BANK_W'(r);
      end
    end
    return tbl;
  endfunction

  localparam logic [RB_TBL_W-1:0] RB_TBL = build_rb_tbl();

  logic [ROM_SIZE_W-1:0] rom_size_code;
  logic [RAM_SIZE_W-1:0] ram_size_code;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic                  ram_enabled;

  logic [DATA_W-1:0]     cart_ram [RAM_DEPTH];
  logic [DATA_W-1:0]     ram_q;
  logic [RAW-1:0]        clr_cnt;

  logic                  out_valid;
  logic                  out_fetch;
  logic [ROM_ADDR_W-1:0] out_addr;
  logic                  out_use_ram;

  logic                  advance;
  logic                  is_read;
  logic [CNT_W-1:0]      ram_n;
  logic                  ram_ok;
  logic [RAW-1:0]        ram_idx;
  logic [3:0]            rom_exp;
  logic [ROM_BANK_W-1:0] rom_mask;
  logic [RAM_BANK_W-1:0] rb_red;
  logic                  mem_we;
  logic [RAW-1:0]        mem_wa;
  logic [DATA_W-1:0]     mem_wd;
  logic                  mem_re;
  logic                  nx_fetch;
  logic [ROM_ADDR_W-1:0] nx_addr;
  logic                  nx_use_ram;

  // Handshake with the queue and the result register
  assign advance = !out_valid || rsp.ready;
  assign pop     = head.valid && advance && !clear_busy;
  assign is_read = head.entry.op inside {OP_RD_ROM0, OP_RD_ROMX, OP_RD_RAM, OP_RD_OPEN};

  // RAM window check and index
  assign ram_n   = ram_banks(ram_size_code);
  assign ram_ok  = ram_enabled && (ram_n != '0) && ({1'b0, ram_bank} < ram_n);
  assign ram_idx = RAW'({ram_bank, head.entry.address[RAM_OFF_W-1:0]});

  // Bank reduction: ROM by mask, RAM by table
  assign rom_exp  = (rom_size_code > 4'(MAX_ROM_EXP)) ? 4'(MAX_ROM_EXP) : rom_size_code;
  assign rom_mask = ROM_BANK_W'((10'd2 << rom_exp) - 10'd1);
  assign rb_red   = RB_TBL[{ram_size_code, head.entry.write_data[3:0], 2'b00} +: RAM_BANK_W];

  // Memory port: the clearing pass owns it after reset
  assign mem_we = clear_busy || (pop && (head.entry.op == OP_RAM_WR) && ram_ok);
  assign mem_wa = clear_busy ? clr_cnt : ram_idx;
  assign mem_wd = clear_busy ? '0 : head.entry.write_data;
  assign mem_re = pop && (head.entry.op == OP_RD_RAM) && ram_ok;

  // Form the next result
  always_comb begin
    nx_fetch   = 1'b0;
    nx_addr    = '0;
    nx_use_ram = 1'b0;
    case (head.entry.op)
      OP_RD_ROM0: begin
        nx_fetch = 1'b1;
        nx_addr  = ROM_ADDR_W'(head.entry.address);
      end
      OP_RD_ROMX: begin
        nx_fetch = 1'b1;
        nx_addr  = {rom_bank, head.entry.address[ROM_OFF_W-1:0]};
      end
      OP_RD_RAM: begin
        nx_use_ram = ram_ok;
      end
      default: begin
        nx_fetch = 1'b0;
      end
    endcase
  end

  // Configuration, bank registers, clearing pass and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= '0;
      ram_size_code <= '0;
      rom_bank      <= ROM_BANK_W'(1);
      ram_bank      <= '0;
      ram_enabled   <= 1'b0;
      clear_busy    <= 1'b1;
      clr_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_ROM_SIZE: rom_size_code <= cfg_data[ROM_SIZE_W-1:0];
          REG_RAM_SIZE: ram_size_code <= cfg_data[RAM_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (clear_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == RAW'(RAM_DEPTH - 1)) begin
          clear_busy <= 1'b0;
        end
      end
      if (pop) begin
        case (head.entry.op)
          OP_RAM_EN:   ram_enabled <= (head.entry.write_data[3:0] == RAM_EN_KEY);
          OP_ROM_LO:   rom_bank <= {rom_bank[ROM_BANK_W-1], head.entry.write_data} & rom_mask;
          OP_ROM_HI:   rom_bank <= {head.entry.write_data[0], rom_bank[7:0]} & rom_mask;
          OP_RAM_BANK: ram_bank <= rb_red;
          default: ;
        endcase
      end
      if (pop && is_read) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && is_read) begin
      out_fetch   <= nx_fetch;
      out_addr    <= nx_addr;
      out_use_ram <= nx_use_ram;
    end
  end

  // Cartridge RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cart_ram[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      ram_q <= cart_ram[ram_idx];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.rom_fetch   = out_fetch;
  assign rsp.rom_address = out_addr;
  assign rsp.read_data   = out_use_ram ? ram_q : (out_fetch ? '0 : OPEN_BUS);

endmodule

[rtl/cartridge_bank_controller_unit.sv]
// Channel   Dir  Payload                                  Handshake
// req       in   cmd, address[15:0], write_data[7:0]      valid / ready
// rsp       out  rom_fetch, rom_address[22:0], read_data  valid / ready
// cfg       in   cfg_index[0], cfg_data[3:0]              cfg_write_en
//
// Sustains one access per cycle while the queue has room and no clearing pass
// runs; a read result waits in a queue slot, then the registered RAM read
// and the result register load on the same edge.
// Writes produce no result. The two-entry queue lets the input run while a
// result waits. After reset a clearing pass zeroes all MAX_RAM_BANKS * 8192
// bytes of the RAM (131072 by default), one byte a cycle, with req.ready low.
// Depends on cbc_pkg, the channel interfaces, cbc_front, cbc_queue, cbc_back.
`timescale 1ns / 1ps
`include "cartridge_bank_controller_unit_macros.svh"
module cartridge_bank_controller_unit
  import cbc_pkg::*;
#(
  parameter int MAX_RAM_BANKS = MAX_RAM_BANKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  cbc_req_if.sink                req,
  cbc_rsp_if.source              rsp,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cbc_slot_t push;
  cbc_slot_t head;
  logic      full;
  logic      pop;
  logic      clear_busy;

  // Classify incoming items
  cbc_front u_front (
    .req        (req),
    .full       (full),
    .clear_busy (clear_busy),
    .push       (push)
  );

  // Buffer classified items
  cbc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // Carry out items and deliver results
  cbc_back #(
    .MAX_RAM_BANKS (MAX_RAM_BANKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .clear_busy   (clear_busy),
    .rsp          (rsp)
  );

  // Clearing pass starts right after reset and blocks input
  `CBC_ASSERT_NOW(a_clear_after_reset, clk, rst, $fell(rst), clear_busy, "clear not running after reset")
  `CBC_ASSERT_NOW(a_clear_blocks_input, clk, rst, clear_busy, !req.ready, "item taken during clear")
  `CBC_ASSERT_NEXT(a_clear_no_result, clk, rst, clear_busy, !rsp.valid, "result during clear")
  // ROM fetches carry zero data; other results carry a zero address
  `CBC_ASSERT_NOW(a_result_fields, clk, rst, rsp.valid, (rsp.rom_fetch ? (rsp.read_data == 8'h00) : (rsp.rom_address == '0)), "result fields inconsistent")

endmodule

[tb/bank_map_checker.sv]
// Bank map checker: watches the access, result and register ports of the controller,
// predicts each read result and compares it with what the controller returns.
// Depends on cbc_pkg and the channel interfaces cbc_req_if / cbc_rsp_if.
`timescale 1ns / 1ps
module bank_map_checker
  import cbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  cbc_req_if                     req,
  cbc_rsp_if                     rsp,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic                  rom_fetch;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_data;
  } fetch_result_t;

  // Expected read results, oldest first
  fetch_result_t expected_fetches[$];

  // Shadow registers and bank state
  logic [ROM_SIZE_W-1:0] rom_code;
  logic [RAM_SIZE_W-1:0] ram_code;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic                  ram_on;
  // Entries missing from the image still hold their cleared value of zero
  logic [DATA_W-1:0]     ram_image [int];

  function automatic int rom_bank_count();
    int c;
    c = (rom_code > MAX_ROM_EXP) ? MAX_ROM_EXP : int'(rom_code);
    return 2 << c;
  endfunction

  function automatic int ram_bank_count();
    case (ram_code)
      3'd1: return 1;
      3'd2: return 4;
      3'd3: return 8;
      3'd4: return 16;
      default: return 0;
    endcase
  endfunction

  // Fold the ROM bank into the bank count in force now
  function automatic void fold_rom_bank();
    int n;
    n = rom_bank_count();
    if (int'(rom_bank) >= n) rom_bank = ROM_BANK_W'(int'(rom_bank) % n);
  endfunction

  // Byte index of a RAM window access, or -1 when the access is refused
  function automatic int ram_slot(input logic [ADDR_W-1:0] addr);
    int n;
    n = ram_bank_count();
    if (!ram_on || n == 0 || int'(ram_bank) >= n) return -1;
    return int'(ram_bank) * RAM_BANK_BYTES + int'(addr - 16'hA000);
  endfunction

  // Advance the bank state by one access; queue the result of a read
  function automatic void apply_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] data);
    int idx;
    int n;
    fetch_result_t res;
    res = '0;
    if (cmd == CMD_WRITE) begin
      if (addr <= 16'h1FFF) begin
        ram_on = (data[3:0] == RAM_EN_KEY);
      end else if (addr <= 16'h2FFF) begin
        rom_bank = {rom_bank[ROM_BANK_W-1], data};
        fold_rom_bank();
      end else if (addr <= 16'h3FFF) begin
        rom_bank = {data[0], rom_bank[ROM_BANK_W-2:0]};
        fold_rom_bank();
      end else if (addr <= 16'h5FFF) begin
        n = ram_bank_count();
        ram_bank = data[RAM_BANK_W-1:0];
        if (int'(ram_bank) >= n) ram_bank = RAM_BANK_W'(int'(ram_bank) % ((n > 0) ? n : 1));
      end else if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
        idx = ram_slot(addr);
        if (idx >= 0) ram_image[idx] = data;
      end
    end else begin
      if (addr <= 16'h3FFF) begin
        res.rom_fetch   = 1'b1;
        res.rom_address = ROM_ADDR_W'(addr);
      end else if (addr <= 16'h7FFF) begin
        // bank times 16 KiB plus offset into the switchable window
        res.rom_fetch   = 1'b1;
        res.rom_address = {rom_bank, addr[ROM_OFF_W-1:0]};
      end else begin
        res.read_data = OPEN_BUS;
        if (addr >= 16'hA000 && addr <= 16'hBFFF) begin
          idx = ram_slot(addr);
          if (idx >= 0) res.read_data = ram_image.exists(idx) ? ram_image[idx] : '0;
        end
      end
      expected_fetches.push_back(res);
    end
  endfunction

  // Track registers, predict accepted items, compare returned results
  always @(posedge clk) begin
    fetch_result_t got;
    fetch_result_t want;
    if (rst) begin
      rom_code = '0;
      ram_code = '0;
      rom_bank = ROM_BANK_W'(1);
      ram_bank = '0;
      ram_on   = 1'b0;
      ram_image.delete();
      expected_fetches.delete();
      mismatches = 0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_ROM_SIZE) rom_code = cfg_data;
        else if (cfg_index == REG_RAM_SIZE) ram_code = cfg_data[RAM_SIZE_W-1:0];
      end
      if (req.valid && req.ready) apply_access(req.cmd, req.address, req.write_data);
      if (rsp.valid && rsp.ready) begin
        got.rom_fetch   = rsp.rom_fetch;
        got.rom_address = rsp.rom_address;
        got.read_data   = rsp.read_data;
        if (expected_fetches.size() == 0) begin
          $error("result with none expected: rom_fetch %0d rom_address %0h read_data %0h",
                 got.rom_fetch, got.rom_address, got.read_data);
          mismatches++;
        end else begin
          want = expected_fetches.pop_front();
          if (got.rom_fetch !== want.rom_fetch) begin
            $error("rom_fetch: expected %0d, got %0d", want.rom_fetch, got.rom_fetch);
            mismatches++;
          end
          if (got.rom_address !== want.rom_address) begin
            $error("rom_address: expected %0h, got %0h", want.rom_address, got.rom_address);
            mismatches++;
          end
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_fetches.size();
  end

endmodule

[tb/tb.sv]
// Testbench top: drives CPU bus accesses and register writes into the bank controller
// with random gaps and stalls; bank_map_checker predicts and compares the results.
// Depends on cbc_pkg, the channel interfaces, bank_map_checker and the controller.
`timescale 1ns / 1ps
module tb;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 105;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;
  int                     cycle_count = 0;
  bit                     calm = 1'b0;

  // Register settings per random phase; extremes and unknown RAM codes included
  int rom_plan [PHASES] = '{0, 8, 15, 3, 9, 2, 5, 1, 8, 4};
  int ram_plan [PHASES] = '{0, 4, 7, 1, 3, 4, 2, 6, 1, 4};

  cbc_req_if req_ch ();
  cbc_rsp_if rsp_ch ();

  cartridge_bank_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bank_map_checker map_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drop the run when it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result side at random, except in calm stretches
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = calm || ($urandom_range(99) >= 35);
    end
  end

  // Offer one item after a random gap, hold it until taken
  task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
    while (!calm && $urandom_range(99) < 35) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.cmd        = cmd;
    req_ch.address    = addr;
    req_ch.write_data = data;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Wait for every expected result, then let trailing writes finish
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Address in the RAM window, often among the first few bytes so reads hit writes
  function automatic logic [ADDR_W-1:0] ram_addr();
    if ($urandom_range(1) == 0) return ADDR_W'(16'hA000 + $urandom_range(15));
    return ADDR_W'(16'hA000 + $urandom_range(16'h1FFF));
  endfunction

  // One random access, weighted toward enabled RAM traffic and ROM reads
  task automatic random_access();
    int                pick;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(99);
    data = DATA_W'($urandom_range(255));
    if (pick < 5) begin
      if ($urandom_range(4) != 0) data[3:0] = RAM_EN_KEY;
      send_access(CMD_WRITE, ADDR_W'($urandom_range(16'h1FFF)), data);
    end else if (pick < 12) begin
      send_access(CMD_WRITE, ADDR_W'($urandom_range(16'h2FFF, 16'h2000)), data);
    end else if (pick < 16) begin
      send_access(CMD_WRITE, ADDR_W'($urandom_range(16'h3FFF, 16'h3000)), data);
    end else if (pick < 24) begin
      send_access(CMD_WRITE, ADDR_W'($urandom_range(16'h5FFF, 16'h4000)), data);
    end else if (pick < 45) begin
      send_access(CMD_WRITE, ram_addr(), data);
    end else if (pick < 65) begin
      send_access(CMD_READ, ram_addr(), data);
    end else if (pick < 75) begin
      send_access(CMD_READ, ADDR_W'($urandom_range(16'h3FFF)), data);
    end else if (pick < 90) begin
      send_access(CMD_READ, ADDR_W'($urandom_range(16'h7FFF, 16'h4000)), data);
    end else if (pick < 95) begin
      if ($urandom_range(1) == 0)
        send_access(CMD_READ, ADDR_W'($urandom_range(16'h9FFF, 16'h8000)), data);
      else
        send_access(CMD_READ, ADDR_W'($urandom_range(16'hFFFF, 16'hC000)), data);
    end else begin
      if ($urandom_range(1) == 0)
        send_access(CMD_WRITE, ADDR_W'($urandom_range(16'h9FFF, 16'h6000)), data);
      else
        send_access(CMD_WRITE, ADDR_W'($urandom_range(16'hFFFF, 16'hC000)), data);
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_index          = REG_ROM_SIZE;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_READ;
    req_ch.address     = '0;
    req_ch.write_data  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: four ROM banks, four RAM banks
    write_reg(REG_ROM_SIZE, 1);
    write_reg(REG_RAM_SIZE, 2);
    // fixed and switchable ROM windows at their edges, reset bank
    send_access(CMD_READ, 16'h0000, 8'h00);
    send_access(CMD_READ, 16'h3FFF, 8'hFF);
    send_access(CMD_READ, 16'h4000, 8'h00);
    send_access(CMD_READ, 16'h7FFF, 8'hFF);
    // RAM disabled reads open bus, then enable and use it
    send_access(CMD_READ, 16'hA000, 8'h00);
    send_access(CMD_WRITE, 16'h0000, 8'h0A);
    send_access(CMD_WRITE, 16'hA000, 8'h5A);
    send_access(CMD_READ, 16'hA000, 8'h00);
    // RAM bank above the count folds down
    send_access(CMD_WRITE, 16'h5FFF, 8'hFF);
    send_access(CMD_WRITE, 16'hBFFF, 8'hC3);
    send_access(CMD_READ, 16'hBFFF, 8'h00);
    // ROM bank zero, then low and high bits folded
    send_access(CMD_WRITE, 16'h2000, 8'h00);
    send_access(CMD_READ, 16'h4000, 8'h00);
    send_access(CMD_WRITE, 16'h2FFF, 8'hFF);
    send_access(CMD_WRITE, 16'h3000, 8'h01);
    send_access(CMD_READ, 16'h7FFF, 8'h00);
    // unmapped ranges
    send_access(CMD_READ, 16'h8000, 8'h00);
    send_access(CMD_READ, 16'h9FFF, 8'h00);
    send_access(CMD_READ, 16'hC000, 8'h00);
    send_access(CMD_READ, 16'hFFFF, 8'h00);
    send_access(CMD_WRITE, 16'h6000, 8'hFF);
    send_access(CMD_WRITE, 16'hC000, 8'hFF);
    // disable with a near-miss key, refused write and read
    send_access(CMD_WRITE, 16'h1FFF, 8'hF5);
    send_access(CMD_WRITE, 16'hBFFF, 8'h11);
    send_access(CMD_READ, 16'hBFFF, 8'h00);

    // Random phases, one register setting each; one phase runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_ROM_SIZE, rom_plan[p]);
      write_reg(REG_RAM_SIZE, ram_plan[p]);
      calm = (p == 3);
      repeat (PHASE_ITEMS) random_access();
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
